FILE: sv/cfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame encoder package
// Frame layout constants, control and status bundles, CRC-16 byte update.
// ----------------------------------------------------------------------------
package cfe_pkg;

	localparam int FRAME_BYTES = 22;
	localparam int BODY_BYTES  = 20;
	localparam int IDX_W       = $clog2(FRAME_BYTES);

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] HDR_B0 = 8'h03;
	localparam logic [7:0] HDR_B1 = 8'h82;
	localparam logic [7:0] HDR_B2 = 8'h00;
	localparam logic [7:0] HDR_B3 = 8'h0C;

	localparam logic [IDX_W-1:0] IDX_HDR0   = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_HDR1   = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_HDR2   = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_HDR3   = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_POS0   = IDX_W'(4);
	localparam logic [IDX_W-1:0] IDX_POS3   = IDX_W'(7);
	localparam logic [IDX_W-1:0] IDX_VEL0   = IDX_W'(8);
	localparam logic [IDX_W-1:0] IDX_VEL3   = IDX_W'(11);
	localparam logic [IDX_W-1:0] IDX_TRQ0   = IDX_W'(12);
	localparam logic [IDX_W-1:0] IDX_TRQ3   = IDX_W'(15);
	localparam logic [IDX_W-1:0] IDX_FLAG1  = IDX_W'(16);
	localparam logic [IDX_W-1:0] IDX_FLAG2  = IDX_W'(17);
	localparam logic [IDX_W-1:0] IDX_FLAG3  = IDX_W'(18);
	localparam logic [IDX_W-1:0] IDX_FLAG4  = IDX_W'(19);
	localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(BODY_BYTES);
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_BYTES - 1);

	typedef struct packed {
		logic load;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_full;
		logic at_last;
	} status_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

FILE: sv/cfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame encoder controller
// Takes one command, then steps the datapath through the 22 frame bytes.
// ----------------------------------------------------------------------------
module cfe_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  logic            frame_stall,
	input  cfe_pkg::status_t status,
	output cfe_pkg::cmd_t   cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic advance;

	assign cmd_stall = (state_q != ST_IDLE);
	assign advance   = (state_q == ST_RUN) && (!status.out_full || !frame_stall);

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && cmd_valid;
		cmd.emit = advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (advance && status.at_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_RUN)
		else $error("load did not start a frame");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.emit))
		else $error("load and emit together");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && status.at_last) |=> state_q == ST_IDLE)
		else $error("frame did not end after last byte");

endmodule

FILE: sv/cfe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame encoder datapath
// Command hold registers, byte select, running CRC and output register.
// ----------------------------------------------------------------------------
module cfe_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfe_pkg::cmd_t               cmd,
	output cfe_pkg::status_t            status,
	input  logic [31:0]                 position_word,
	input  logic [31:0]                 velocity_word,
	input  logic [31:0]                 torque_word,
	input  logic                        flag_one,
	input  logic                        flag_two,
	input  logic                        flag_three,
	input  logic                        flag_four,
	input  logic                        frame_stall,
	output logic                        frame_valid,
	output logic [7:0]                  frame_byte,
	output logic                        frame_last
);

	logic [31:0] pos_q;
	logic [31:0] vel_q;
	logic [31:0] trq_q;
	logic [3:0]  flags_q;
	logic [cfe_pkg::IDX_W-1:0] idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [7:0]  sel_byte;

	always_comb begin
		case (idx_q) inside
			cfe_pkg::IDX_HDR0:                       sel_byte = cfe_pkg::HDR_B0;
			cfe_pkg::IDX_HDR1:                       sel_byte = cfe_pkg::HDR_B1;
			cfe_pkg::IDX_HDR2:                       sel_byte = cfe_pkg::HDR_B2;
			cfe_pkg::IDX_HDR3:                       sel_byte = cfe_pkg::HDR_B3;
			[cfe_pkg::IDX_POS0:cfe_pkg::IDX_POS3]:   sel_byte = pos_q[idx_q[1:0]*8 +: 8];
			[cfe_pkg::IDX_VEL0:cfe_pkg::IDX_VEL3]:   sel_byte = vel_q[idx_q[1:0]*8 +: 8];
			[cfe_pkg::IDX_TRQ0:cfe_pkg::IDX_TRQ3]:   sel_byte = trq_q[idx_q[1:0]*8 +: 8];
			cfe_pkg::IDX_FLAG1:                      sel_byte = {7'd0, flags_q[0]};
			cfe_pkg::IDX_FLAG2:                      sel_byte = {7'd0, flags_q[1]};
			cfe_pkg::IDX_FLAG3:                      sel_byte = {7'd0, flags_q[2]};
			cfe_pkg::IDX_FLAG4:                      sel_byte = {7'd0, flags_q[3]};
			cfe_pkg::IDX_CRC_HI:                     sel_byte = crc_q[15:8];
			default:                                 sel_byte = crc_q[7:0];
		endcase
	end

	always_comb begin
		status.out_full = out_valid_q;
		status.at_last  = (idx_q == cfe_pkg::IDX_LAST);
	end

	assign frame_valid = out_valid_q;
	assign frame_byte  = byte_q;
	assign frame_last  = last_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q   <= position_word;
			vel_q   <= velocity_word;
			trq_q   <= torque_word;
			flags_q <= {flag_four, flag_three, flag_two, flag_one};
		end
		if (cmd.emit) begin
			byte_q <= sel_byte;
			last_q <= (idx_q == cfe_pkg::IDX_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			crc_q       <= cfe_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				crc_q <= cfe_pkg::CRC_INIT;
			end else if (cmd.emit) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q < cfe_pkg::IDX_CRC_HI) crc_q <= cfe_pkg::crc_update(crc_q, sel_byte);
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!frame_stall) out_valid_q <= 1'b0;
		end
	end

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (idx_q == '0) && (crc_q == cfe_pkg::CRC_INIT))
		else $error("load did not clear index and crc");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> idx_q <= cfe_pkg::IDX_LAST)
		else $error("byte index out of range");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> frame_valid && (frame_last == ($past(idx_q) == cfe_pkg::IDX_LAST)))
		else $error("last flag mismatch");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !frame_stall))
		else $error("emit overwrote a held byte");

endmodule

FILE: sv/axis_command_frame_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame encoder
// Turns one motion command into a 22-byte frame with a CRC-16 trailer.
//
//   channel   direction  handshake                payload
//   cmd       in         cmd_valid / cmd_stall    three words, four flags
//   frame     out        frame_valid / frame_stall frame_byte, frame_last
//
// A command is loaded, then its 22 bytes pass through the byte select and CRC
// update, one per cycle unless a full output register is held by frame_stall.
// cmd_stall is high from load until the last byte enters the output register.
// frame_stall holds the output register and, while it is full, pauses the byte counter.
// Reset clears the controller, counter and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module axis_command_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [31:0] position_word,
	input  logic [31:0] velocity_word,
	input  logic [31:0] torque_word,
	input  logic        flag_one,
	input  logic        flag_two,
	input  logic        flag_three,
	input  logic        flag_four,
	output logic        frame_valid,
	input  logic        frame_stall,
	output logic [7:0]  frame_byte,
	output logic        frame_last
);

	cfe_pkg::cmd_t    cmd;
	cfe_pkg::status_t status;

	cfe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.frame_stall (frame_stall),
		.status      (status),
		.cmd         (cmd)
	);

	cfe_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.position_word (position_word),
		.velocity_word (velocity_word),
		.torque_word   (torque_word),
		.flag_one      (flag_one),
		.flag_two      (flag_two),
		.flag_three    (flag_three),
		.flag_four     (flag_four),
		.frame_stall   (frame_stall),
		.frame_valid   (frame_valid),
		.frame_byte    (frame_byte),
		.frame_last    (frame_last)
	);

endmodule

FILE: bench/cfe_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame checker
// Watches the command and frame channels of the command frame encoder. Every
// accepted command is expanded into the 22 bytes it should produce: header,
// three little-endian words, four flag bytes, and a CRC-16/CCITT-FALSE
// trailer sent high byte first. Every accepted output byte is compared with
// the oldest byte still pending. Mismatches and stray bytes are counted.
// ----------------------------------------------------------------------------
module cfe_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  logic [31:0] position_word,
	input  logic [31:0] velocity_word,
	input  logic [31:0] torque_word,
	input  logic        flag_one,
	input  logic        flag_two,
	input  logic        flag_three,
	input  logic        flag_four,
	input  logic        frame_valid,
	input  logic        frame_stall,
	input  logic [7:0]  frame_byte,
	input  logic        frame_last,
	output int          fail_count,
	output int          pending,
	output int          bytes_seen
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	frame_beat_t frame_bytes_q[$];

	function automatic logic [31:0] little_endian(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// Bitwise CRC over the body, first byte in the top bits.
	function automatic logic [15:0] crc16_ccitt_false(
		input logic [8*cfe_pkg::BODY_BYTES-1:0] body
	);
		logic [15:0] crc;
		logic        fb;
		crc = cfe_pkg::CRC_INIT;
		for (int i = 8 * cfe_pkg::BODY_BYTES - 1; i >= 0; i--) begin
			fb  = crc[15] ^ body[i];
			crc = {crc[14:0], 1'b0} ^ (fb ? cfe_pkg::CRC_POLY : 16'h0000);
		end
		return crc;
	endfunction

	task automatic queue_frame(
		input logic [31:0] pos,
		input logic [31:0] vel,
		input logic [31:0] trq,
		input logic [3:0]  flags
	);
		logic [8*cfe_pkg::BODY_BYTES-1:0]  body;
		logic [8*cfe_pkg::FRAME_BYTES-1:0] frame;
		frame_beat_t                       beat;
		body = {cfe_pkg::HDR_B0, cfe_pkg::HDR_B1, cfe_pkg::HDR_B2, cfe_pkg::HDR_B3,
			little_endian(pos), little_endian(vel), little_endian(trq),
			7'd0, flags[3], 7'd0, flags[2], 7'd0, flags[1], 7'd0, flags[0]};
		frame = {body, crc16_ccitt_false(body)};
		for (int k = 0; k < cfe_pkg::FRAME_BYTES; k++) begin
			beat.data = frame[8 * (cfe_pkg::FRAME_BYTES - 1 - k) +: 8];
			beat.last = (k == cfe_pkg::FRAME_BYTES - 1);
			frame_bytes_q = {frame_bytes_q, beat};
		end
	endtask

	always @(posedge clk) begin : watch
		frame_beat_t want;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				queue_frame(position_word, velocity_word, torque_word,
					{flag_one, flag_two, flag_three, flag_four});
			if (frame_valid && !frame_stall) begin
				bytes_seen++;
				if (frame_bytes_q.size() == 0) begin
					$error("frame_byte %02h frame_last %0b with no frame pending",
						frame_byte, frame_last);
					fail_count++;
				end else begin
					want = frame_bytes_q.pop_front();
					if (frame_byte !== want.data) begin
						$error("frame_byte expected %02h actual %02h", want.data, frame_byte);
						fail_count++;
					end
					if (frame_last !== want.last) begin
						$error("frame_last expected %0b actual %0b", want.last, frame_last);
						fail_count++;
					end
				end
			end
		end
		pending = frame_bytes_q.size();
	end

endmodule

FILE: bench/axis_command_frame_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame encoder testbench
// Drives directed and random motion commands into the encoder under four
// handshake mixes and one long output hold, while the frame checker predicts
// and compares every byte. Prints the verdict when all frames have drained.
// ----------------------------------------------------------------------------
module axis_command_frame_encoder_unit_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	logic [31:0] position_word;
	logic [31:0] velocity_word;
	logic [31:0] torque_word;
	logic        flag_one;
	logic        flag_two;
	logic        flag_three;
	logic        flag_four;
	logic        frame_valid;
	logic        frame_stall;
	logic [7:0]  frame_byte;
	logic        frame_last;

	int fail_count;
	int pending;
	int bytes_seen;
	int cmds_sent;
	int cycles;
	int send_idle_pct;
	int stall_pct;
	logic hold_armed;

	axis_command_frame_encoder_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.position_word (position_word),
		.velocity_word (velocity_word),
		.torque_word   (torque_word),
		.flag_one      (flag_one),
		.flag_two      (flag_two),
		.flag_three    (flag_three),
		.flag_four     (flag_four),
		.frame_valid   (frame_valid),
		.frame_stall   (frame_stall),
		.frame_byte    (frame_byte),
		.frame_last    (frame_last)
	);

	cfe_frame_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.position_word (position_word),
		.velocity_word (velocity_word),
		.torque_word   (torque_word),
		.flag_one      (flag_one),
		.flag_two      (flag_two),
		.flag_three    (flag_three),
		.flag_four     (flag_four),
		.frame_valid   (frame_valid),
		.frame_stall   (frame_stall),
		.frame_byte    (frame_byte),
		.frame_last    (frame_last),
		.fail_count    (fail_count),
		.pending       (pending),
		.bytes_seen    (bytes_seen)
	);

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("axis_command_frame_encoder_unit_tb failed");
			$finish;
		end
	end

	// Output side: random stall, plus one long hold once armed.
	initial begin : frame_sink
		logic hold_taken;
		hold_taken  = 1'b0;
		frame_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_taken) begin
				hold_taken = 1'b1;
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					frame_stall <= 1'b1;
					@(negedge clk);
				end
			end
			frame_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return {1'($urandom_range(0, 1)), 8'($urandom_range(120, 135)), 23'($urandom)};
			3: return 32'h8000_0000 >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	// Offer one transaction; returns at the falling edge after acceptance.
	task automatic send_cmd(
		input logic [31:0] pos,
		input logic [31:0] vel,
		input logic [31:0] trq,
		input logic [3:0]  flags
	);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid     <= 1'b1;
		position_word <= pos;
		velocity_word <= vel;
		torque_word   <= trq;
		{flag_one, flag_two, flag_three, flag_four} <= flags;
		do
			@(posedge clk);
		while (cmd_stall);
		cmds_sent++;
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_cmd(pick_word(), pick_word(), pick_word(), 4'($urandom));
	endtask

	initial begin
		cmds_sent     = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_armed    = 1'b0;
		arst_n        = 1'b0;
		cmd_valid     = 1'b0;
		position_word = '0;
		velocity_word = '0;
		torque_word   = '0;
		flag_one      = 1'b0;
		flag_two      = 1'b0;
		flag_three    = 1'b0;
		flag_four     = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_cmd(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'b0000);
		send_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b1111);
		send_cmd(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 4'b1010);
		send_cmd(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 4'b0101);
		send_cmd(32'h3F80_0000, 32'hBF80_0000, 32'h0000_0000, 4'b1000);
		send_cmd(32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 4'b0100);
		send_cmd(32'h8000_0000, 32'h0000_0001, 32'h7F7F_FFFF, 4'b0010);
		send_cmd(32'h0080_0000, 32'h007F_FFFF, 32'h8000_0001, 4'b0001);
		send_cmd(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C, 4'b0110);
		send_cmd(32'h0300_820C, 32'h0C00_8203, 32'hFFFF_0000, 4'b1001);

		send_random(60);

		hold_armed = 1'b1;
		send_random(20);

		send_idle_pct = 58;
		stall_pct     = 0;
		send_random(78);

		send_idle_pct = 0;
		stall_pct     = 58;
		send_random(78);

		send_idle_pct = 11;
		stall_pct     = 11;
		send_random(64);

		cmd_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (pending != 0)
			$error("%0d frame bytes never arrived", pending);
		$display("Covered %0d commands: directed corners, random words and flags,",
			cmds_sent);
		$display("four idle/stall mixes and a %0d-cycle output hold; %0d bytes compared.",
			HOLD_CYCLES, bytes_seen);
		if (fail_count == 0 && pending == 0)
			$display("axis_command_frame_encoder_unit_tb passed");
		else
			$display("axis_command_frame_encoder_unit_tb failed");
		$finish;
	end

endmodule
